[src/ufwr_pkg.sv]
// Package for the union-find wall removal block: grid sizes, widths,
// register codes, port structs and cell-index helpers.
// No dependencies; all other files refer to it by scoped names.
`default_nettype none

package ufwr_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int CELL_W   = $clog2(CELLS);
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int SIZE_W   = 7;
    localparam int COUNT_W  = 13;
    localparam int CFG_W    = 7;
    localparam int IDX_W    = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_ROWS       = 2'd0,
        REG_COLS       = 2'd1,
        REG_UNIQUE     = 2'd2,
        REG_ALL_JOINED = 2'd3
    } t_reg_idx;

    // configuration as seen by the sequencer; clear pulses on a size write
    typedef struct packed {
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] cols;
        logic              unique_paths;
        logic              need_all_joined;
        logic              clear;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [CELL_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [CELL_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [CELL_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return CELL_W'(row) * CELL_W'(MAX_COLS) + CELL_W'(col);
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                     input int max_size);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (int'(v) > max_size) begin
            return SIZE_W'(max_size);
        end
        return SIZE_W'(v);
    endfunction

endpackage

`default_nettype wire

[src/ufwr_set_store.sv]
// Parent store of the disjoint-set forest: one write port and one read port,
// read data registered. Uses ufwr_pkg for widths and the request struct.
`default_nettype none

module ufwr_set_store (
    input  wire logic                      i_clk,
    input  wire ufwr_pkg::t_mem_req        i_req,
    output logic [ufwr_pkg::CELL_W-1:0]    o_rdata
);

    logic [ufwr_pkg::CELL_W-1:0] r_mem [ufwr_pkg::CELLS];
    logic [ufwr_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/ufwr_ctrl.sv]
// Sequencer around the shared find unit: clearing pass, root finds with
// path halving, set merge, finish check and the result register. Uses ufwr_pkg.
`default_nettype none

module ufwr_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ufwr_pkg::t_cfg                i_cfg,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [ufwr_pkg::ROW_W-1:0]    i_cell_row,
    input  wire logic [ufwr_pkg::COL_W-1:0]    i_cell_col,
    input  wire logic                          i_wall_side,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_wall_removed,
    output logic                               o_item_ignored,
    output logic                               o_maze_done,
    output logic [ufwr_pkg::COUNT_W-1:0]       o_sets_left,
    output ufwr_pkg::t_mem_req                 o_mem_req,
    input  wire logic [ufwr_pkg::CELL_W-1:0]   i_mem_rdata
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ISSUE = 6'b000100,
        S_RX    = 6'b001000,
        S_RP    = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // which root is being looked for
    typedef enum logic [1:0] {
        PH_CELL  = 2'd0,
        PH_OTHER = 2'd1,
        PH_ENTRY = 2'd2,
        PH_EXIT  = 2'd3
    } t_phase;

    localparam int PROD_W = 2 * ufwr_pkg::SIZE_W;

    t_state                         r_state, n_state;
    t_phase                         r_phase, n_phase;
    logic [ufwr_pkg::CELL_W-1:0]    r_x, n_x;
    logic [ufwr_pkg::CELL_W-1:0]    r_other, n_other;
    logic [ufwr_pkg::CELL_W-1:0]    r_ra, n_ra;
    logic [ufwr_pkg::CELL_W-1:0]    r_rc, n_rc;
    logic [ufwr_pkg::CELL_W-1:0]    r_clr_idx, n_clr_idx;
    logic [ufwr_pkg::COUNT_W-1:0]   r_count, n_count;
    logic                           r_ignored, n_ignored;
    logic                           r_removed, n_removed;
    logic                           r_join, n_join;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_removed, n_out_removed;
    logic                           r_out_ignored, n_out_ignored;
    logic                           r_out_done, n_out_done;
    logic [ufwr_pkg::COUNT_W-1:0]   r_out_sets, n_out_sets;

    ufwr_pkg::t_mem_req             mem_req;
    logic                           in_accept;
    logic                           in_ignored;
    logic                           merge_go;
    logic [ufwr_pkg::CELL_W-1:0]    in_cell;
    logic [ufwr_pkg::CELL_W-1:0]    in_other;
    logic [ufwr_pkg::CELL_W-1:0]    exit_cell;
    logic [PROD_W-1:0]              size_prod;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign in_cell  = ufwr_pkg::cell_index(i_cell_row, i_cell_col);
    assign in_other = i_wall_side ? (in_cell - ufwr_pkg::CELL_W'(1))
                                  : (in_cell - ufwr_pkg::CELL_W'(ufwr_pkg::MAX_COLS));
    assign in_ignored = (ufwr_pkg::SIZE_W'(i_cell_row) >= i_cfg.rows)
                     || (ufwr_pkg::SIZE_W'(i_cell_col) >= i_cfg.cols)
                     || (!i_wall_side && (i_cell_row == '0))
                     || (i_wall_side && (i_cell_col == '0));

    assign exit_cell = ufwr_pkg::cell_index(
        ufwr_pkg::ROW_W'(i_cfg.rows - ufwr_pkg::SIZE_W'(1)),
        ufwr_pkg::COL_W'(i_cfg.cols - ufwr_pkg::SIZE_W'(1)));
    assign size_prod = PROD_W'(i_cfg.rows) * PROD_W'(i_cfg.cols);

    assign merge_go = !i_cfg.unique_paths || (r_ra != r_x);

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_x           = r_x;
        n_other       = r_other;
        n_ra          = r_ra;
        n_rc          = r_rc;
        n_clr_idx     = r_clr_idx;
        n_count       = r_count;
        n_ignored     = r_ignored;
        n_removed     = r_removed;
        n_join        = r_join;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_removed = r_out_removed;
        n_out_ignored = r_out_ignored;
        n_out_done    = r_out_done;
        n_out_sets    = r_out_sets;
        mem_req       = '0;
        mem_req.raddr = r_x;

        unique case (r_state)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_clr_idx;
                mem_req.wdata = r_clr_idx;
                n_count       = ufwr_pkg::COUNT_W'(size_prod);
                n_clr_idx     = r_clr_idx + ufwr_pkg::CELL_W'(1);
                if (r_clr_idx == ufwr_pkg::CELL_W'(ufwr_pkg::CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_other   = in_other;
                    n_ignored = in_ignored;
                    n_removed = 1'b0;
                    if (!in_ignored) begin
                        n_x     = in_cell;
                        n_phase = PH_CELL;
                        n_state = S_ISSUE;
                    end else if (i_cfg.need_all_joined) begin
                        n_state = S_OUT;
                    end else begin
                        n_x     = '0;
                        n_phase = PH_ENTRY;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                mem_req.raddr = r_x;
                n_state       = S_RX;
            end
            S_RX: begin
                if (i_mem_rdata != r_x) begin
                    // not a root: fetch the grandparent
                    mem_req.raddr = i_mem_rdata;
                    n_state       = S_RP;
                end else begin
                    unique case (r_phase)
                        PH_CELL: begin
                            n_ra          = r_x;
                            n_x           = r_other;
                            mem_req.raddr = r_other;
                            n_phase       = PH_OTHER;
                        end
                        PH_OTHER: begin
                            n_removed = merge_go;
                            if (merge_go && (r_ra != r_x)) begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = r_ra;
                                mem_req.wdata = r_x;
                                if (r_count > ufwr_pkg::COUNT_W'(1)) begin
                                    n_count = r_count - ufwr_pkg::COUNT_W'(1);
                                end
                            end
                            if (i_cfg.need_all_joined) begin
                                n_state = S_OUT;
                            end else begin
                                // reissue after the merge write settles
                                n_x     = '0;
                                n_phase = PH_ENTRY;
                                n_state = S_ISSUE;
                            end
                        end
                        PH_ENTRY: begin
                            n_rc          = r_x;
                            n_x           = exit_cell;
                            mem_req.raddr = exit_cell;
                            n_phase       = PH_EXIT;
                        end
                        PH_EXIT: begin
                            n_join  = (r_rc == r_x);
                            n_state = S_OUT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_RP: begin
                // path halving: point x at its grandparent and carry on from there
                mem_req.we    = 1'b1;
                mem_req.waddr = r_x;
                mem_req.wdata = i_mem_rdata;
                mem_req.raddr = i_mem_rdata;
                n_x           = i_mem_rdata;
                n_state       = S_RX;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_removed = r_removed;
                    n_out_ignored = r_ignored;
                    n_out_done    = i_cfg.need_all_joined ? (r_count == ufwr_pkg::COUNT_W'(1))
                                                          : r_join;
                    n_out_sets    = r_count;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        if (i_cfg.clear) begin
            n_state   = S_CLEAR;
            n_clr_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_CELL;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x           <= n_x;
        r_other       <= n_other;
        r_ra          <= n_ra;
        r_rc          <= n_rc;
        r_count       <= n_count;
        r_ignored     <= n_ignored;
        r_removed     <= n_removed;
        r_join        <= n_join;
        r_out_removed <= n_out_removed;
        r_out_ignored <= n_out_ignored;
        r_out_done    <= n_out_done;
        r_out_sets    <= n_out_sets;
    end

    assign o_mem_req      = mem_req;
    assign o_out_valid    = r_out_valid;
    assign o_wall_removed = r_out_removed;
    assign o_item_ignored = r_out_ignored;
    assign o_maze_done    = r_out_done;
    assign o_sets_left    = r_out_sets;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("sequencer still idle after an input transfer");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_count != '0))
        else $error("set count reached zero");

    a_merge_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.we && (r_state == S_RX)) |-> (r_phase == PH_OTHER))
        else $error("merge write outside the merge step");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside the output step");

endmodule

`default_nettype wire

[src/union_find_wall_removal.sv]
// Union-find wall removal: config registers, sequencer and parent store.
// Per item: idle, issue and output steps, plus a read and halving steps per root find,
// and one more issue step for the entry/exit check when the one-set goal is off.
// One item at a time (idle, output if ignored under the one-set goal); results wait.
// Synchronous active-low reset, then a clearing pass over every cell (also after
// every rows or cols write) during which no item is taken.
`default_nettype none

module union_find_wall_removal (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ufwr_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [ufwr_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [ufwr_pkg::ROW_W-1:0]    i_cell_row,
    input  wire logic [ufwr_pkg::COL_W-1:0]    i_cell_col,
    input  wire logic                          i_wall_side,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_wall_removed,
    output logic                               o_item_ignored,
    output logic                               o_maze_done,
    output logic [ufwr_pkg::COUNT_W-1:0]       o_sets_left
);

    logic [ufwr_pkg::SIZE_W-1:0]   r_rows;
    logic [ufwr_pkg::SIZE_W-1:0]   r_cols;
    logic                          r_unique;
    logic                          r_all_joined;
    ufwr_pkg::t_reg_idx            cfg_idx;
    ufwr_pkg::t_cfg                cfg;
    ufwr_pkg::t_mem_req            mem_req;
    logic [ufwr_pkg::CELL_W-1:0]   mem_rdata;

    assign cfg_idx = ufwr_pkg::t_reg_idx'(i_cfg_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows       <= ufwr_pkg::clamp_size(ufwr_pkg::CFG_W'(64), ufwr_pkg::MAX_ROWS);
            r_cols       <= ufwr_pkg::clamp_size(ufwr_pkg::CFG_W'(64), ufwr_pkg::MAX_COLS);
            r_unique     <= 1'b1;
            r_all_joined <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (cfg_idx)
                ufwr_pkg::REG_ROWS: begin
                    r_rows <= ufwr_pkg::clamp_size(i_cfg_data, ufwr_pkg::MAX_ROWS);
                end
                ufwr_pkg::REG_COLS: begin
                    r_cols <= ufwr_pkg::clamp_size(i_cfg_data, ufwr_pkg::MAX_COLS);
                end
                ufwr_pkg::REG_UNIQUE: begin
                    r_unique <= i_cfg_data[0];
                end
                ufwr_pkg::REG_ALL_JOINED: begin
                    r_all_joined <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.rows            = r_rows;
        cfg.cols            = r_cols;
        cfg.unique_paths    = r_unique;
        cfg.need_all_joined = r_all_joined;
        // a size change restarts the clearing pass
        cfg.clear           = i_cfg_we && ((cfg_idx == ufwr_pkg::REG_ROWS)
                                        || (cfg_idx == ufwr_pkg::REG_COLS));
    end

    ufwr_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_wall_side    (i_wall_side),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_wall_removed (o_wall_removed),
        .o_item_ignored (o_item_ignored),
        .o_maze_done    (o_maze_done),
        .o_sets_left    (o_sets_left),
        .o_mem_req      (mem_req),
        .i_mem_rdata    (mem_rdata)
    );

    ufwr_set_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

[tb/union_find_wall_removal_test.sv]
`timescale 1ns / 1ps
// Testbench for union_find_wall_removal: drives shuffled interior walls and
// noise over many grid settings and checks every result against its own
// disjoint-set predictor. Needs ufwr_pkg and the block itself.

module union_find_wall_removal_test;

    localparam logic SIDE_ABOVE       = 1'b0;
    localparam logic SIDE_LEFT        = 1'b1;
    localparam int   RANDOM_WALLS     = 1850;
    localparam int   CALM_WALLS       = 250;
    localparam int   MAX_PHASES       = 48;
    localparam int   FULL_PLAN_LIMIT  = 220;
    localparam int   SPARSE_WALLS     = 150;
    localparam int   LONG_HOLD_CYCLES = 300;
    localparam int   PRINT_LIMIT      = 40;
    localparam longint TIMEOUT_NS     = 64'd60_000_000;

    typedef struct packed {
        logic [ufwr_pkg::ROW_W-1:0] row;
        logic [ufwr_pkg::COL_W-1:0] col;
        logic                       side;
    } t_wall;

    typedef struct packed {
        logic                         removed;
        logic                         ignored;
        logic                         done;
        logic [ufwr_pkg::COUNT_W-1:0] sets;
    } t_wall_result;

    // Disjoint-set predictor and the results it still owes.
    class t_maze_scoreboard;
        logic [ufwr_pkg::CELL_W-1:0] set_parent [ufwr_pkg::CELLS];
        int unsigned  set_count;
        int unsigned  grid_rows;
        int unsigned  grid_cols;
        bit           unique_paths;
        bit           need_all_joined;
        t_wall_result pending_results[$];
        int unsigned  mismatches;
        int unsigned  results_checked;
        int unsigned  walls_noted;
        int unsigned  removed_seen;
        int unsigned  ignored_seen;
        int unsigned  done_seen;

        function int unsigned fit_dim(logic [ufwr_pkg::CFG_W-1:0] v, int unsigned limit);
            if (v == '0) begin
                return 1;
            end
            if (v > limit) begin
                return limit;
            end
            return v;
        endfunction

        function void clear_store();
            for (int i = 0; i < ufwr_pkg::CELLS; i++) begin
                set_parent[i] = ufwr_pkg::CELL_W'(i);
            end
            set_count = grid_rows * grid_cols;
        endfunction

        function void reset_state();
            grid_rows       = ufwr_pkg::MAX_ROWS;
            grid_cols       = ufwr_pkg::MAX_COLS;
            unique_paths    = 1'b1;
            need_all_joined = 1'b0;
            clear_store();
        endfunction

        function void set_register(ufwr_pkg::t_reg_idx idx, logic [ufwr_pkg::CFG_W-1:0] data);
            case (idx)
                ufwr_pkg::REG_ROWS: begin
                    grid_rows = fit_dim(data, ufwr_pkg::MAX_ROWS);
                    clear_store();
                end
                ufwr_pkg::REG_COLS: begin
                    grid_cols = fit_dim(data, ufwr_pkg::MAX_COLS);
                    clear_store();
                end
                ufwr_pkg::REG_UNIQUE:     unique_paths = data[0];
                ufwr_pkg::REG_ALL_JOINED: need_all_joined = data[0];
                default: ;
            endcase
        endfunction

        // Root lookup with path halving, as the sequencer does it.
        function int unsigned root_of(int unsigned x);
            int unsigned p;
            int unsigned gp;
            while (set_parent[x] != x) begin
                p  = set_parent[x];
                gp = set_parent[p];
                set_parent[x] = ufwr_pkg::CELL_W'(gp);
                x  = gp;
            end
            return x;
        endfunction

        function void note_wall(t_wall w);
            t_wall_result r;
            int unsigned  cell_idx;
            int unsigned  other;
            int unsigned  ra;
            int unsigned  rb;
            int unsigned  exit_cell;
            r = '0;
            if (w.row >= grid_rows || w.col >= grid_cols ||
                (w.side == SIDE_ABOVE && w.row == 0) || (w.side == SIDE_LEFT && w.col == 0)) begin
                r.ignored = 1'b1;
            end else begin
                cell_idx = w.row * ufwr_pkg::MAX_COLS + w.col;
                other    = (w.side == SIDE_ABOVE) ? cell_idx - ufwr_pkg::MAX_COLS
                                                  : cell_idx - 1;
                if (!(unique_paths && root_of(cell_idx) == root_of(other))) begin
                    ra = root_of(cell_idx);
                    rb = root_of(other);
                    if (ra != rb) begin
                        set_parent[ra] = ufwr_pkg::CELL_W'(rb);
                        if (set_count > 1) begin
                            set_count--;
                        end
                    end
                    r.removed = 1'b1;
                end
            end
            if (need_all_joined) begin
                r.done = (set_count == 1);
            end else begin
                exit_cell = (grid_rows - 1) * ufwr_pkg::MAX_COLS + (grid_cols - 1);
                r.done = (root_of(0) == root_of(exit_cell));
            end
            r.sets = ufwr_pkg::COUNT_W'(set_count);
            walls_noted++;
            removed_seen += r.removed;
            ignored_seen += r.ignored;
            done_seen    += r.done;
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            if (mismatches < PRINT_LIMIT) begin
                $display("%t mismatch on result %0d: %s got %0d want %0d",
                         $realtime, results_checked, what, got, want);
            end
            mismatches++;
        endtask

        task check_result(t_wall_result got);
            t_wall_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, sets_left", got.sets, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.removed !== want.removed) begin
                    report_mismatch("wall_removed", got.removed, want.removed);
                end
                if (got.ignored !== want.ignored) begin
                    report_mismatch("item_ignored", got.ignored, want.ignored);
                end
                if (got.done !== want.done) begin
                    report_mismatch("maze_done", got.done, want.done);
                end
                if (got.sets !== want.sets) begin
                    report_mismatch("sets_left", got.sets, want.sets);
                end
            end
            results_checked++;
        endtask
    endclass

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [ufwr_pkg::IDX_W-1:0]   cfg_idx   = '0;
    logic [ufwr_pkg::CFG_W-1:0]   cfg_data  = '0;
    logic                         in_valid  = 1'b0;
    logic [ufwr_pkg::ROW_W-1:0]   cell_row  = '0;
    logic [ufwr_pkg::COL_W-1:0]   cell_col  = '0;
    logic                         wall_side = 1'b0;
    logic                         out_stall = 1'b0;
    logic                         in_stall;
    logic                         out_valid;
    logic                         wall_removed;
    logic                         item_ignored;
    logic                         maze_done;
    logic [ufwr_pkg::COUNT_W-1:0] sets_left;

    bit          calm          = 1'b0;
    bit          long_hold_req = 1'b0;
    t_wall       wall_plan[$];
    t_maze_scoreboard sb;

    union_find_wall_removal dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cell_row     (cell_row),
        .i_cell_col     (cell_col),
        .i_wall_side    (wall_side),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_wall_removed (wall_removed),
        .o_item_ignored (item_ignored),
        .o_maze_done    (maze_done),
        .o_sets_left    (sets_left)
    );

    always #10 clk = ~clk;

    // Note each input transfer and check each result transfer.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                sb.check_result('{wall_removed, item_ignored, maze_done, sets_left});
            end
            if (in_valid && !in_stall) begin
                sb.note_wall('{cell_row, cell_col, wall_side});
            end
        end
    end

    // Receiver: random stall bursts, one long hold on request, none when calm.
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                out_stall = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
                out_stall = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[union_find_wall_removal] ERROR");
        $finish;
    end

    task automatic write_reg(input ufwr_pkg::t_reg_idx idx, input logic [ufwr_pkg::CFG_W-1:0] data);
        @(negedge clk);
        sb.set_register(idx, data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Offer one wall, after an optional gap; return at its transfer.
    task automatic send_wall(input t_wall w);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        cell_row  = w.row;
        cell_col  = w.col;
        wall_side = w.side;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_at(input int r, input int c, input logic s);
        t_wall w;
        w.row  = ufwr_pkg::ROW_W'(r);
        w.col  = ufwr_pkg::COL_W'(c);
        w.side = s;
        send_wall(w);
    endtask

    task automatic send_noise();
        send_at($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    endtask

    // Drop valid and wait for every owed result.
    task automatic quiesce();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    function automatic logic [ufwr_pkg::CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 7'd0;
            1:       return 7'd127;
            2:       return 7'd64;
            3:       return 7'd1;
            4:       return 7'($urandom_range(10, 63));
            default: return 7'($urandom_range(2, 9));
        endcase
    endfunction

    // Every interior wall in shuffled order, or a random sample on big grids.
    task automatic plan_walls();
        int unsigned rows;
        int unsigned cols;
        int          total;
        int          j;
        t_wall       w;
        t_wall       t;
        rows = sb.grid_rows;
        cols = sb.grid_cols;
        wall_plan.delete();
        total = rows * (cols - 1) + (rows - 1) * cols;
        if (total <= FULL_PLAN_LIMIT) begin
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < cols; c++) begin
                    w.row = ufwr_pkg::ROW_W'(r);
                    w.col = ufwr_pkg::COL_W'(c);
                    if (r > 0) begin
                        w.side = SIDE_ABOVE;
                        wall_plan.push_back(w);
                    end
                    if (c > 0) begin
                        w.side = SIDE_LEFT;
                        wall_plan.push_back(w);
                    end
                end
            end
            for (int i = wall_plan.size() - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                t = wall_plan[i];
                wall_plan[i] = wall_plan[j];
                wall_plan[j] = t;
            end
        end else begin
            repeat (SPARSE_WALLS) begin
                if (rows > 1 && (cols == 1 || $urandom_range(0, 1) == 0)) begin
                    w.row  = ufwr_pkg::ROW_W'($urandom_range(1, rows - 1));
                    w.col  = ufwr_pkg::COL_W'($urandom_range(0, cols - 1));
                    w.side = SIDE_ABOVE;
                end else begin
                    w.row  = ufwr_pkg::ROW_W'($urandom_range(0, rows - 1));
                    w.col  = ufwr_pkg::COL_W'($urandom_range(1, cols - 1));
                    w.side = SIDE_LEFT;
                end
                wall_plan.push_back(w);
            end
        end
    endtask

    initial begin
        int walls_sent;
        int phase_no;
        bit hold_done;
        bit pause_done;
        walls_sent = 0;
        phase_no   = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        sb = new();
        sb.reset_state();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Reset setting: edges, far corner, a loop refused in unique mode.
        send_at(0, 0, SIDE_ABOVE);
        send_at(0, 0, SIDE_LEFT);
        send_at(0, 63, SIDE_ABOVE);
        send_at(63, 0, SIDE_LEFT);
        send_at(63, 63, SIDE_ABOVE);
        send_at(63, 63, SIDE_LEFT);
        send_at(1, 0, SIDE_ABOVE);
        send_at(0, 1, SIDE_LEFT);
        send_at(1, 1, SIDE_ABOVE);
        send_at(1, 1, SIDE_LEFT);
        quiesce();
        // Mode change keeps the sets: same loop now goes, cleared wall again.
        write_reg(ufwr_pkg::REG_UNIQUE, 7'd0);
        send_at(1, 1, SIDE_LEFT);
        send_at(63, 63, SIDE_ABOVE);
        quiesce();
        write_reg(ufwr_pkg::REG_ALL_JOINED, 7'd1);
        send_at(42, 21, SIDE_LEFT);
        quiesce();
        // Out-of-range sizes saturate: one row of 64 columns.
        write_reg(ufwr_pkg::REG_ROWS, 7'd0);
        write_reg(ufwr_pkg::REG_COLS, 7'd127);
        send_at(1, 5, SIDE_LEFT);
        send_at(0, 63, SIDE_LEFT);
        send_at(0, 0, SIDE_LEFT);
        send_at(0, 5, SIDE_ABOVE);
        send_at(63, 63, SIDE_LEFT);
        quiesce();
        // Single cell: finished from the start under both conditions.
        write_reg(ufwr_pkg::REG_ROWS, 7'd1);
        write_reg(ufwr_pkg::REG_COLS, 7'd1);
        send_at(0, 0, SIDE_ABOVE);
        send_at(0, 0, SIDE_LEFT);
        quiesce();
        write_reg(ufwr_pkg::REG_ALL_JOINED, 7'd0);
        send_at(63, 63, SIDE_ABOVE);
        quiesce();

        while (walls_sent < RANDOM_WALLS && phase_no < MAX_PHASES) begin
            if (phase_no == 0 || $urandom_range(0, 4) != 0) begin
                write_reg(ufwr_pkg::REG_ROWS, pick_size());
                write_reg(ufwr_pkg::REG_COLS, pick_size());
            end
            write_reg(ufwr_pkg::REG_UNIQUE, 7'($urandom_range(0, 1)));
            write_reg(ufwr_pkg::REG_ALL_JOINED, 7'($urandom_range(0, 1)));
            plan_walls();
            if (walls_sent >= RANDOM_WALLS - CALM_WALLS) begin
                calm = 1'b1;
            end
            if (!hold_done && wall_plan.size() >= 12) begin
                long_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            send_noise();
            send_noise();
            walls_sent += 2;
            foreach (wall_plan[i]) begin
                if (hold_done && !pause_done && i == wall_plan.size() / 2) begin
                    quiesce();
                    pause_done = 1'b1;
                end
                if ($urandom_range(0, 7) == 0) begin
                    send_noise();
                    walls_sent++;
                end
                send_wall(wall_plan[i]);
                walls_sent++;
                if ($urandom_range(0, 15) == 0) begin
                    send_wall(wall_plan[$urandom_range(0, i)]);
                    walls_sent++;
                end
            end
            quiesce();
            phase_no++;
        end

        repeat (50) @(posedge clk);
        $display("covered %0d walls over %0d random grid settings: %0d removed, %0d ignored",
                 sb.walls_noted, phase_no, sb.removed_seen, sb.ignored_seen);
        $display("%0d results reported a finished maze; %0d results checked, %0d mismatches",
                 sb.done_seen, sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("[union_find_wall_removal] OK");
        end else begin
            $display("[union_find_wall_removal] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
src/ufwr_pkg.sv
src/ufwr_set_store.sv
src/ufwr_ctrl.sv
src/union_find_wall_removal.sv
tb/union_find_wall_removal_test.sv
